>>> rtl/msa_pkg.sv
package msa_pkg;

	localparam int CHANNELS    = 5;
	localparam int DEPTH       = 8;
	localparam int SAMPLE_BITS = 12;

	// Fixed field widths of the item ports
	localparam int CH_W     = 3;
	localparam int SMP_IN_W = 12;
	localparam int AVG_W    = 12;
	localparam int SMP_EXT_W = 16;

	localparam int POS_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W   = SAMPLE_BITS + $clog2(DEPTH);
	localparam int ENTRIES = CHANNELS * DEPTH;
	localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	localparam logic MODE_BLOCK  = 1'b0;
	localparam logic MODE_MOVING = 1'b1;

	function automatic logic [AVG_W-1:0] depth_avg(input logic [SUM_W-1:0] sum);
		return AVG_W'(sum / DEPTH);
	endfunction

endpackage

>>> rtl/msa_if.sv
interface msa_in_if import msa_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                operation;
	logic [CH_W-1:0]     channel;
	logic [SMP_IN_W-1:0] sample;

	modport source(output valid, operation, channel, sample, input ready);
	modport sink(input valid, operation, channel, sample, output ready);
endinterface

interface msa_out_if import msa_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  out_channel;
	logic [AVG_W-1:0] average;
	logic             frame_last;

	modport source(output valid, out_channel, average, frame_last, input ready);
	modport sink(input valid, out_channel, average, frame_last, output ready);
endinterface

>>> rtl/msa_ring.sv
module msa_ring import msa_pkg::*;
(
	input  logic                   clk,
	input  logic                   we,
	input  logic [ADDR_W-1:0]      waddr,
	input  logic [SAMPLE_BITS-1:0] wdata,
	input  logic                   re,
	input  logic [ADDR_W-1:0]      raddr,
	output logic [SAMPLE_BITS-1:0] rdata
);

	logic [SAMPLE_BITS-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/multichannel_sample_averager.sv
// Per-channel averager for scanned converter samples, one item per clock sustained. An item
// is accepted and its ring entry read from the single-port-read sample memory; then, in the
// update stage, the running sum is updated, in moving mode the entry is written back, and
// a result, if one is due, is loaded into the output register; a same-entry write/read
// overlap is forwarded. Input ready drops only while a result-producing item is held
// because the output register is full and not being taken. Clear and a change of
// average_mode take effect at once through per-entry valid bits: no clearing pass.
module multichannel_sample_averager import msa_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data,
	msa_in_if.sink        samples,
	msa_out_if.source     results
);

	logic                   mode_q;
	logic [POS_W-1:0]       pos_q;
	logic [SUM_W-1:0]       sums_q [CHANNELS];
	logic [ENTRIES-1:0]     ring_vld_q;

	logic                   vld_s1;
	logic                   op_s1;
	logic [CH_W-1:0]        ch_s1;
	logic [SAMPLE_BITS-1:0] smp_s1;
	logic [POS_W-1:0]       pos_s1;
	logic [ADDR_W-1:0]      addr_s1;

	logic                   fwd_vld_q;
	logic [ADDR_W-1:0]      fwd_addr_q;
	logic [SAMPLE_BITS-1:0] fwd_data_q;

	logic                   out_vld_q;
	logic [CH_W-1:0]        out_ch_q;
	logic [AVG_W-1:0]       avg_q;
	logic                   last_q;

	logic                   cfg_clr;
	logic                   in_fire;
	logic                   ch_ok;
	logic                   take;
	logic [SMP_EXT_W-1:0]   smp_ext;
	logic [ADDR_W-1:0]      addr_in;
	logic [SAMPLE_BITS-1:0] rdata;

	logic                   last_s1;
	logic                   fwd_hit;
	logic [SAMPLE_BITS-1:0] old_smp;
	logic [SUM_W-1:0]       sum_cur;
	logic [SUM_W-1:0]       sum_add;
	logic [SUM_W-1:0]       sum_mov;
	logic                   emit_s1;
	logic                   out_free;
	logic                   s1_fire;
	logic                   adv;
	logic                   ring_we;
	logic                   s1_clr;

	assign cfg_clr = cfg_wr_en && (cfg_wr_data != mode_q);

	// Accept side
	assign samples.ready = adv;
	assign in_fire = samples.valid && samples.ready;
	assign ch_ok   = 32'(samples.channel) < CHANNELS;
	assign take    = in_fire && ((samples.operation == OP_CLEAR) || ch_ok);
	assign smp_ext = SMP_EXT_W'(samples.sample);
	assign addr_in = ADDR_W'(samples.channel) * ADDR_W'(DEPTH) + ADDR_W'(pos_q);

	msa_ring u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (addr_s1),
		.wdata (smp_s1),
		.re    (adv),
		.raddr (addr_in),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BLOCK;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// Frame position moves at accept time, so the next item addresses the right entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cfg_clr) begin
			pos_q <= '0;
		end else if (in_fire && samples.operation == OP_CLEAR) begin
			pos_q <= '0;
		end else if (in_fire && ch_ok && 32'(samples.channel) == CHANNELS - 1) begin
			pos_q <= (pos_q == POS_W'(DEPTH - 1)) ? '0 : pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= samples.operation;
			ch_s1   <= samples.channel;
			smp_s1  <= smp_ext[SAMPLE_BITS-1:0];
			pos_s1  <= pos_q;
			addr_s1 <= addr_in;
		end
	end

	// Update stage
	assign last_s1 = 32'(ch_s1) == CHANNELS - 1;
	assign fwd_hit = fwd_vld_q && (fwd_addr_q == addr_s1);
	assign old_smp = fwd_hit ? fwd_data_q : (ring_vld_q[addr_s1] ? rdata : '0);
	assign sum_cur = sums_q[ch_s1];
	assign sum_add = sum_cur + SUM_W'(smp_s1);
	assign sum_mov = sum_cur - SUM_W'(old_smp) + SUM_W'(smp_s1);
	assign emit_s1 = (op_s1 == OP_SAMPLE)
		&& ((mode_q == MODE_MOVING) || (pos_s1 == POS_W'(DEPTH - 1)));

	assign out_free = !out_vld_q || results.ready;
	assign s1_fire  = vld_s1 && (!emit_s1 || out_free);
	assign adv      = !vld_s1 || s1_fire;
	assign s1_clr   = s1_fire && (op_s1 == OP_CLEAR);
	assign ring_we  = s1_fire && (op_s1 == OP_SAMPLE) && (mode_q == MODE_MOVING) && !cfg_clr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sums_q[i] <= '0;
			end
		end else if (cfg_clr || s1_clr) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sums_q[i] <= '0;
			end
		end else if (s1_fire) begin
			if (mode_q == MODE_MOVING) begin
				sums_q[ch_s1] <= sum_mov;
			end else begin
				sums_q[ch_s1] <= emit_s1 ? '0 : sum_add;
			end
		end
	end

	// Entries never written since the last clear read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
		end else if (cfg_clr || s1_clr) begin
			ring_vld_q <= '0;
		end else if (ring_we) begin
			ring_vld_q[addr_s1] <= 1'b1;
		end
	end

	// Remember the write that lands on the same edge as the next read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (cfg_clr) begin
			fwd_vld_q <= 1'b0;
		end else if (adv) begin
			fwd_vld_q <= ring_we;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= smp_s1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_fire && emit_s1) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit_s1) begin
			out_ch_q <= ch_s1;
			avg_q    <= depth_avg((mode_q == MODE_MOVING) ? sum_mov : sum_add);
			last_q   <= last_s1;
		end
	end

	assign results.valid       = out_vld_q;
	assign results.out_channel = out_ch_q;
	assign results.average     = avg_q;
	assign results.frame_last  = last_q;

	a_stall_blocks_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !s1_fire) |-> !samples.ready)
		else $error("item accepted while update stage is held");

	a_emit_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && emit_s1) |=> out_vld_q)
		else $error("result lost on its way to the output register");

	a_clear_empties_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_clr || cfg_clr) |=> (ring_vld_q == '0 && !fwd_vld_q))
		else $error("ring entries survive a clear");

	a_mode_change_resets_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_clr |=> (pos_q == '0))
		else $error("frame position not cleared on mode change");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(DEPTH - 1))
		else $error("frame position beyond ring depth");

endmodule
